// ===== hdl/quote_aware_comment_stripper_macros.svh =====
// ----------------------------------------------------------------------------
// quote_aware_comment_stripper assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in rst
// ----------------------------------------------------------------------------
`ifndef QUOTE_AWARE_COMMENT_STRIPPER_MACROS_SVH
`define QUOTE_AWARE_COMMENT_STRIPPER_MACROS_SVH

// same-cycle implication
`define QACS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("comment stripper check failed");

// next-cycle implication
`define QACS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("comment stripper check failed");

`endif

// ===== hdl/qacs_pkg.sv =====
// ----------------------------------------------------------------------------
// qacs_pkg
// character codes, comment kinds and result types of the comment stripper
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package qacs_pkg;

  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_NL    = 8'h0A;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_LINE  = 2'd1,
    KIND_BLOCK = 2'd2
  } comment_kind_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       run_last;
    logic       text_end;
  } res_t;

  typedef struct packed {
    logic [1:0] count;
    res_t       first;
    res_t       second;
  } step_out_t;

endpackage

// ===== hdl/qacs_if.sv =====
// ----------------------------------------------------------------------------
// qacs stream interfaces
// valid/ready channels for raw text beats and stripped result beats
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface qacs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       text_last;

  modport source (output valid, output in_byte, output text_last, input ready);
  modport sink   (input valid, input in_byte, input text_last, output ready);
endinterface

interface qacs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       run_last;
  logic       text_end;

  modport source (output valid, output out_byte, output byte_valid,
                  output run_last, output text_end, input ready);
  modport sink   (input valid, input out_byte, input byte_valid,
                  input run_last, input text_end, output ready);
endinterface

// ===== hdl/quote_aware_comment_stripper.sv =====
// ----------------------------------------------------------------------------
// quote_aware_comment_stripper
// removes C-style comments from a byte stream, quote aware, no escapes
// ----------------------------------------------------------------------------
// up: one text byte per beat, text_last on the final byte of a text.
// dn: result beats; each input byte gives zero, one or two beats, run_last
//   marks the last beat of one input byte, text_end the last of the text.
//   A text end with nothing to emit gives one beat with byte_valid low.
// Path: an accepted byte waits in the input latch, is decided by the core
//   and is loaded into the result register once that can take it; its
//   beats are then offered on dn from the result register.
// Throughput: one byte per cycle while each byte yields at most one beat
//   and dn.ready stays high; a byte that yields two beats holds the result
//   register until both drain, and dn then sets the rate, one beat per cycle.
// Bytes that yield no beat (comment text, a held slash) pass at one per
//   cycle even while dn is stalled, as long as the input latch can drain.
// Reset (rst, synchronous): leaves quotes, comments and any held slash,
//   and empties both the input latch and the result register.
// Stall: when dn.ready is low the result register holds its beats and the
//   input latch stops after one waiting byte; up.ready then drops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module quote_aware_comment_stripper (
  input  logic        clk,
  input  logic        rst,
  qacs_in_if.sink     up,
  qacs_out_if.source  dn
);
  import qacs_pkg::*;

  logic       in_vld;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  step_out_t  step;
  logic       free;
  logic       consume;

  assign consume  = in_vld && (step.count == 2'd0 || free);
  assign up.ready = !in_vld || consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (up.ready) begin
      in_vld <= up.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up.valid && up.ready) begin
      in_byte_q <= up.in_byte;
      in_last_q <= up.text_last;
    end
  end

  qacs_core u_core (
    .clk       (clk),
    .rst       (rst),
    .advance   (consume),
    .in_byte   (in_byte_q),
    .text_last (in_last_q),
    .step      (step)
  );

  qacs_outbuf u_outbuf (
    .clk  (clk),
    .rst  (rst),
    .load (consume && step.count != 2'd0),
    .step (step),
    .free (free),
    .dn   (dn)
  );

endmodule

// ===== hdl/qacs_core.sv =====
// ----------------------------------------------------------------------------
// qacs_core
// scan state and per-byte decision: up to two result beats for one text byte
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qacs_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  logic [7:0]         in_byte,
  input  logic               text_last,
  output qacs_pkg::step_out_t step
);
  import qacs_pkg::*;

  logic          in_quote, in_quote_next;
  comment_kind_t kind, kind_next;
  logic          star_seen, star_seen_next;
  logic          slash_held, slash_held_next;

  logic [1:0] n;
  logic [7:0] e0, e1;
  logic       bare;

  always_comb begin
    in_quote_next   = in_quote;
    kind_next       = kind;
    star_seen_next  = star_seen;
    slash_held_next = slash_held;
    n    = 2'd0;
    e0   = 8'h00;
    e1   = 8'h00;
    bare = 1'b0;

    case (kind)
      KIND_BLOCK: begin
        if (star_seen && in_byte == CH_SLASH) begin
          kind_next      = KIND_NONE;
          star_seen_next = 1'b0;
        end else begin
          star_seen_next = (in_byte == CH_STAR);
        end
      end
      KIND_LINE: begin
        if (in_byte == CH_NL) begin
          kind_next = KIND_NONE;
          e0 = in_byte;
          n  = 2'd1;
        end
      end
      default: begin
        if (slash_held) begin
          slash_held_next = 1'b0;
          if (in_byte == CH_SLASH) begin
            kind_next = KIND_LINE;
          end else if (in_byte == CH_STAR) begin
            kind_next      = KIND_BLOCK;
            star_seen_next = 1'b0;
          end else begin
            e0 = CH_SLASH;
            e1 = in_byte;
            n  = 2'd2;
            if (in_byte == CH_QUOTE) in_quote_next = ~in_quote;
          end
        end else if (in_byte == CH_QUOTE) begin
          in_quote_next = ~in_quote;
          e0 = in_byte;
          n  = 2'd1;
        end else if (!in_quote && in_byte == CH_SLASH) begin
          slash_held_next = 1'b1;
        end else begin
          e0 = in_byte;
          n  = 2'd1;
        end
      end
    endcase

    if (text_last) begin
      // flush: held slash or dangling comment opener
      if (slash_held_next) begin
        e0 = CH_SLASH;
        n  = 2'd1;
      end else if (kind_next == KIND_LINE) begin
        e0 = CH_SLASH;
        e1 = CH_SLASH;
        n  = 2'd2;
      end else if (kind_next == KIND_BLOCK) begin
        e0 = CH_SLASH;
        e1 = CH_STAR;
        n  = 2'd2;
      end
      if (n == 2'd0) begin
        e0   = 8'h00;
        n    = 2'd1;
        bare = 1'b1;
      end
      in_quote_next   = 1'b0;
      kind_next       = KIND_NONE;
      star_seen_next  = 1'b0;
      slash_held_next = 1'b0;
    end
  end

  always_comb begin
    step.count              = n;
    step.first.out_byte     = e0;
    step.first.byte_valid   = ~bare;
    step.first.run_last     = (n == 2'd1);
    step.first.text_end     = text_last && (n == 2'd1);
    step.second.out_byte    = e1;
    step.second.byte_valid  = 1'b1;
    step.second.run_last    = 1'b1;
    step.second.text_end    = text_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_quote   <= 1'b0;
      kind       <= KIND_NONE;
      star_seen  <= 1'b0;
      slash_held <= 1'b0;
    end else if (advance) begin
      in_quote   <= in_quote_next;
      kind       <= kind_next;
      star_seen  <= star_seen_next;
      slash_held <= slash_held_next;
    end
  end

endmodule

// ===== hdl/qacs_outbuf.sv =====
// ----------------------------------------------------------------------------
// qacs_outbuf
// two-entry result register, drains one beat per cycle while dn.ready is high
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qacs_outbuf (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  qacs_pkg::step_out_t step,
  output logic               free,
  qacs_out_if.source         dn
);
  import qacs_pkg::*;

  logic [1:0] cnt, cnt_next;
  res_t       slot0, slot1;
  logic       pop;

  assign pop  = dn.valid && dn.ready;
  assign free = (cnt == 2'd0) || (cnt == 2'd1 && pop);

  always_comb begin
    cnt_next = cnt;
    if (load) begin
      cnt_next = step.count;
    end else if (pop) begin
      cnt_next = cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slot0 <= step.first;
      slot1 <= step.second;
    end else if (pop && cnt == 2'd2) begin
      slot0 <= slot1;
    end
  end

  assign dn.valid      = (cnt != 2'd0);
  assign dn.out_byte   = slot0.out_byte;
  assign dn.byte_valid = slot0.byte_valid;
  assign dn.run_last   = slot0.run_last;
  assign dn.text_end   = slot0.text_end;

endmodule

// ===== hdl/qacs_checker.sv =====
// ----------------------------------------------------------------------------
// qacs_checker
// port-level checks on the result channel of the comment stripper
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "quote_aware_comment_stripper_macros.svh"

module qacs_checker (
  input logic       clk,
  input logic       rst,
  input logic       dn_valid,
  input logic       dn_ready,
  input logic [7:0] dn_out_byte,
  input logic       dn_byte_valid,
  input logic       dn_run_last,
  input logic       dn_text_end
);

  // held beat stays offered
  `QACS_ASSERT_NEXT(a_dn_hold, dn_valid && !dn_ready, dn_valid)

  // held beat keeps its byte and its text_end flag
  `QACS_ASSERT_NEXT(a_dn_stable, dn_valid && !dn_ready, $stable(dn_out_byte) && $stable(dn_text_end))

  // end of text closes the run of its byte
  `QACS_ASSERT_NOW(a_end_closes_run, dn_valid && dn_text_end, dn_run_last)

  // bare end marker is zero and ends the text
  `QACS_ASSERT_NOW(a_bare_marker, dn_valid && !dn_byte_valid, dn_out_byte == 8'h00 && dn_text_end)

endmodule

bind quote_aware_comment_stripper qacs_checker u_qacs_checker (
  .clk           (clk),
  .rst           (rst),
  .dn_valid      (dn.valid),
  .dn_ready      (dn.ready),
  .dn_out_byte   (dn.out_byte),
  .dn_byte_valid (dn.byte_valid),
  .dn_run_last   (dn.run_last),
  .dn_text_end   (dn.text_end)
);

// ===== sim/strip_checker.sv =====
// ----------------------------------------------------------------------------
// strip_checker
// watches the raw text and result channels of the comment stripper, tracks
// quote, comment and held-slash state per accepted byte, and compares every
// result beat field by field against the oldest predicted beat
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module strip_checker (
  input  logic  clk,
  input  logic  rst,
  qacs_in_if    up,
  qacs_out_if   dn,
  output int    errors,
  output int    outstanding
);
  import qacs_pkg::*;

  logic          in_quote;
  comment_kind_t kind;
  logic          star_seen;
  logic          slash_held;
  res_t          pending_beats[$];

  function automatic res_t kept(input logic [7:0] b);
    return '{out_byte: b, byte_valid: 1'b1, run_last: 1'b0, text_end: 1'b0};
  endfunction

  task automatic strip_byte(input logic [7:0] c, input logic last);
    res_t beats[2];
    int   n;
    n = 0;
    if (kind == KIND_BLOCK) begin
      if (star_seen && c == CH_SLASH) begin
        kind      = KIND_NONE;
        star_seen = 1'b0;
      end else begin
        star_seen = (c == CH_STAR);
      end
    end else if (kind == KIND_LINE) begin
      if (c == CH_NL) begin
        kind = KIND_NONE;
        beats[n] = kept(c);
        n++;
      end
    end else if (slash_held) begin
      slash_held = 1'b0;
      if (c == CH_SLASH) begin
        kind = KIND_LINE;
      end else if (c == CH_STAR) begin
        kind      = KIND_BLOCK;
        star_seen = 1'b0;
      end else begin
        beats[n] = kept(CH_SLASH);
        n++;
        if (c == CH_QUOTE) in_quote = ~in_quote;
        beats[n] = kept(c);
        n++;
      end
    end else if (c == CH_QUOTE) begin
      in_quote = ~in_quote;
      beats[n] = kept(c);
      n++;
    end else if (!in_quote && c == CH_SLASH) begin
      slash_held = 1'b1;
    end else begin
      beats[n] = kept(c);
      n++;
    end

    if (last) begin
      // unterminated comment leaves only its opener
      if (slash_held) begin
        beats[n] = kept(CH_SLASH);
        n++;
      end else if (kind == KIND_LINE) begin
        beats[0] = kept(CH_SLASH);
        beats[1] = kept(CH_SLASH);
        n = 2;
      end else if (kind == KIND_BLOCK) begin
        beats[0] = kept(CH_SLASH);
        beats[1] = kept(CH_STAR);
        n = 2;
      end
      if (n == 0) begin
        beats[0] = '{out_byte: 8'h00, byte_valid: 1'b0, run_last: 1'b0, text_end: 1'b0};
        n = 1;
      end
      in_quote   = 1'b0;
      kind       = KIND_NONE;
      star_seen  = 1'b0;
      slash_held = 1'b0;
    end

    if (n > 0) begin
      beats[n-1].run_last = 1'b1;
      beats[n-1].text_end = last;
    end
    for (int i = 0; i < n; i++) pending_beats.push_back(beats[i]);
  endtask

  always @(posedge clk) begin : monitor
    res_t got;
    res_t want;
    if (rst) begin
      in_quote   = 1'b0;
      kind       = KIND_NONE;
      star_seen  = 1'b0;
      slash_held = 1'b0;
      pending_beats.delete();
      errors     <= 0;
    end else begin
      if (up.valid === 1'b1 && up.ready === 1'b1) strip_byte(up.in_byte, up.text_last);
      if (dn.valid === 1'b1 && dn.ready === 1'b1) begin
        got = '{out_byte: dn.out_byte, byte_valid: dn.byte_valid,
                run_last: dn.run_last, text_end: dn.text_end};
        if (pending_beats.size() == 0) begin
          $display("%0t: unexpected beat, actual byte=%h valid=%b run_last=%b text_end=%b",
                   $time, got.out_byte, got.byte_valid, got.run_last, got.text_end);
          errors <= errors + 1;
        end else begin
          want = pending_beats.pop_front();
          if (got.out_byte !== want.out_byte || got.byte_valid !== want.byte_valid ||
              got.run_last !== want.run_last || got.text_end !== want.text_end) begin
            $display("%0t: beat mismatch, expected byte=%h valid=%b run_last=%b text_end=%b",
                     $time, want.out_byte, want.byte_valid, want.run_last, want.text_end);
            $display("%0t:                  actual byte=%h valid=%b run_last=%b text_end=%b",
                     $time, got.out_byte, got.byte_valid, got.run_last, got.text_end);
            errors <= errors + 1;
          end
        end
      end
    end
    outstanding <= pending_beats.size();
  end

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// drives directed and random texts into the comment stripper with random
// gaps on the input and random stalls on the output, and gives the verdict
// from the checker's error count and any beats still awaited at the end
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import qacs_pkg::*;

  typedef logic [7:0] text_t[$];

  localparam int TOTAL_BYTES = 550;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst;
  int   errors;
  int   outstanding;
  int   sent;

  qacs_in_if  up ();
  qacs_out_if dn ();

  quote_aware_comment_stripper dut (
    .clk (clk),
    .rst (rst),
    .up  (up),
    .dn  (dn)
  );

  strip_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .up          (up),
    .dn          (dn),
    .errors      (errors),
    .outstanding (outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mostly short pauses, a few long ones
  function automatic int pick_pause(input bit allow_zero);
    int r;
    r = $urandom_range(0, 99);
    if (allow_zero && r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 94) return $urandom_range(4, 8);
    return $urandom_range(15, 40);
  endfunction

  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) return CH_SLASH;
    if (r < 37) return CH_STAR;
    if (r < 47) return CH_QUOTE;
    if (r < 55) return CH_NL;
    if (r < 85) return 8'($urandom_range(8'h61, 8'h7a));
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last, input bit burst);
    int gap;
    gap = burst ? 0 : pick_pause(1'b1);
    if (gap > 0) begin
      up.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    up.valid     <= 1'b1;
    up.in_byte   <= b;
    up.text_last <= last;
    do @(posedge clk); while (up.ready !== 1'b1);
    sent++;
  endtask

  task automatic send_text(input text_t t, input bit burst);
    foreach (t[i]) send_byte(t[i], i == t.size() - 1, burst);
  endtask

  // output stall pattern
  initial begin : rx_stall
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 9) < 2) begin
        dn.ready <= 1'b1;
        repeat ($urandom_range(20, 80)) @(posedge clk);
      end else begin
        dn.ready <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        dn.ready <= 1'b0;
        repeat (pick_pause(1'b0) - 1) @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    text_t t;
    int    len;
    bit    held_off;
    bit    noise;
    sent     = 0;
    held_off = 1'b0;
    rst          <= 1'b1;
    up.valid     <= 1'b0;
    up.in_byte   <= 8'h00;
    up.text_last <= 1'b0;
    dn.ready     <= 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // held slash then a plain byte
    send_text('{CH_SLASH, 8'h00}, 1'b0);
    // opener inside quotes is text
    send_text('{CH_QUOTE, CH_SLASH, CH_STAR, CH_QUOTE}, 1'b1);
    // line comment ended by newline
    send_text('{CH_SLASH, CH_SLASH, CH_NL}, 1'b0);
    // slash star slash does not close, byte after close is handled
    send_text('{CH_SLASH, CH_STAR, CH_SLASH, CH_STAR, CH_SLASH, "q"}, 1'b0);
    // end inside line comment
    send_text('{CH_SLASH, CH_SLASH}, 1'b1);
    // end inside block comment
    send_text('{CH_SLASH, CH_STAR}, 1'b0);
    // end with slash held
    send_text('{8'hff, CH_SLASH}, 1'b0);
    // end right at a block close, nothing to emit
    send_text('{CH_SLASH, CH_STAR, CH_STAR, CH_SLASH}, 1'b0);

    while (sent < TOTAL_BYTES) begin
      if (!held_off && sent >= TOTAL_BYTES / 2) begin
        held_off = 1'b1;
        up.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
      end
      t.delete();
      len   = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 20);
      noise = ($urandom_range(0, 99) < 15);
      repeat (len) t.push_back(noise ? 8'($urandom_range(0, 255)) : pick_char());
      send_text(t, $urandom_range(0, 3) == 0);
    end

    up.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (outstanding != 0) $display("%0t: %0d beats never arrived", $time, outstanding);
    if (errors == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
